// ----- sv/pdu_signal_bit_packer_macros.svh -----
`ifndef PDU_SIGNAL_BIT_PACKER_MACROS_SVH
`define PDU_SIGNAL_BIT_PACKER_MACROS_SVH

// clocked check, held off while in reset
`define PSBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked check that also runs through reset
`define PSBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- sv/psbp_pkg.sv -----
package psbp_pkg;

    localparam int PDU_BYTES    = 64;
    localparam int BYTE_W       = 8;
    localparam int PDU_BITS     = PDU_BYTES * BYTE_W;
    localparam int ADDR_W       = $clog2(PDU_BYTES);
    localparam int SIG_MAX_BITS = 64;
    localparam int SIZE_W       = 7;
    localparam int POS_W        = 9;
    localparam int IDX_W        = 6;
    localparam int LANE_W       = SIG_MAX_BITS + BYTE_W;
    localparam int PDU_BITS_W   = $clog2(PDU_BITS + 1);
    localparam int CMP_W        = (PDU_BITS_W > POS_W + 1) ? PDU_BITS_W + 1 : POS_W + 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the input transaction
        logic fetch;  // read the byte at the current address
        logic merge;  // write merged byte, read the next one
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic err;
        logic empty;  // no mask bits left
        logic last;   // current byte is the final one
    } t_sts;

endpackage

// ----- sv/psbp_dpath.sv -----
module psbp_dpath
    import psbp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic                    i_command,
    input  logic [POS_W-1:0]        i_bit_position,
    input  logic [SIZE_W-1:0]       i_bit_size,
    input  logic [SIG_MAX_BITS-1:0] i_signal_value,
    input  logic [IDX_W-1:0]        i_byte_index,
    output t_sts                    o_sts,
    output logic [BYTE_W-1:0]       o_res_byte,
    output logic                    o_res_err
);

    logic [BYTE_W-1:0] r_mem [PDU_BYTES];
    logic [PDU_BYTES-1:0] r_vld;

    logic              r_is_read;
    logic              r_err;
    logic              r_rd_ok;
    t_addr             r_addr;
    logic [LANE_W-1:0] r_data;
    logic [LANE_W-1:0] r_mask;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_vld;

    logic [SIZE_W-1:0]       size_sat;
    logic [SIG_MAX_BITS-1:0] base_mask;
    logic [CMP_W-1:0]        end_bit;
    logic                    n_err;
    logic                    n_rd_ok;
    t_addr                   n_addr;
    t_addr                   rd_addr;
    logic [BYTE_W-1:0]       old_byte;
    logic [BYTE_W-1:0]       new_byte;

    always_comb begin
        size_sat = (i_bit_size > SIZE_W'(SIG_MAX_BITS)) ? SIZE_W'(SIG_MAX_BITS) : i_bit_size;
        for (int i = 0; i < SIG_MAX_BITS; i++) begin
            base_mask[i] = (SIZE_W'(i) < size_sat);
        end
        end_bit = CMP_W'(i_bit_position) + CMP_W'(size_sat);
        n_err   = (end_bit > CMP_W'(PDU_BITS));
        n_rd_ok = (CMP_W'(i_byte_index) < CMP_W'(PDU_BYTES));
        n_addr  = (i_command == CMD_READ) ? ADDR_W'(i_byte_index)
                                          : ADDR_W'(i_bit_position[POS_W-1:3]);
        rd_addr = i_cmd.merge ? ADDR_W'(r_addr + 1'b1) : r_addr;
        old_byte = r_rd_vld ? r_rd_data : '0;
        new_byte = (old_byte & ~r_mask[BYTE_W-1:0]) | (r_data[BYTE_W-1:0] & r_mask[BYTE_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= (i_command == CMD_READ);
            r_err     <= n_err;
            r_rd_ok   <= n_rd_ok;
            r_addr    <= n_addr;
            r_data    <= LANE_W'(i_signal_value) << i_bit_position[2:0];
            r_mask    <= LANE_W'(base_mask) << i_bit_position[2:0];
        end else if (i_cmd.merge) begin
            r_addr <= ADDR_W'(r_addr + 1'b1);
            r_data <= r_data >> BYTE_W;
            r_mask <= r_mask >> BYTE_W;
        end
    end

    // byte store with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.merge) begin
            r_mem[r_addr] <= new_byte;
        end
        if (i_cmd.fetch || i_cmd.merge) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // per-byte written flags; an unwritten byte reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.merge) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (i_cmd.fetch || i_cmd.merge) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    assign o_sts.is_read = r_is_read;
    assign o_sts.err     = r_err;
    assign o_sts.empty   = (r_mask == '0);
    assign o_sts.last    = (r_mask[LANE_W-1:BYTE_W] == '0);

    assign o_res_byte = (r_is_read && r_rd_ok && r_rd_vld) ? r_rd_data : '0;
    assign o_res_err  = !r_is_read && r_err;

endmodule

// ----- sv/psbp_ctrl.sv -----
`include "pdu_signal_bit_packer_macros.svh"

module psbp_ctrl
    import psbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_out_free,
    input  t_sts i_sts,
    output logic o_ready,
    output logic o_out_load,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_ready    = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_read) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_DONE;
                end else if (i_sts.err || i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PSBP_ASSERT(a_merge_after_fetch, o_cmd.merge |-> ($past(o_cmd.fetch) || $past(o_cmd.merge)), "merge without a preceding byte read")
    `PSBP_ASSERT(a_no_write_on_err, o_cmd.merge |-> (!i_sts.err && !i_sts.is_read), "byte write on a read or range-error transaction")
    `PSBP_ASSERT(a_merge_has_mask, o_cmd.merge |-> !i_sts.empty, "byte write with an empty mask")
    `PSBP_ASSERT_ALWAYS(a_load_only_idle, o_cmd.load |=> (r_state == S_START), "transaction captured outside idle")

endmodule

// ----- sv/pdu_signal_bit_packer.sv -----
// Signal packer over one 64-byte PDU held in a byte-wide store, all zero after
// reset. A write transaction (command 0) places the low bit_size bits of
// signal_value (sizes above 64 count as 64) at bit_position, Intel bit order,
// leaving every other PDU bit as it was; a write running past the PDU end
// changes nothing and returns range_error = 1. A read transaction (command 1)
// returns the byte at byte_index. Every transaction yields one result.
// A write reads, merges and writes back each PDU byte that the signal spans (1 to
// 9), one byte per cycle through the byte store, which writes one byte and reads
// the next in the same cycle; a read, a rejected write or a zero-size write writes
// no byte.
// Results sit in an output register, so one finished result may wait while the
// next transaction is accepted.
module pdu_signal_bit_packer
    import psbp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic [POS_W-1:0]        i_bit_position,
    input  logic [SIZE_W-1:0]       i_bit_size,
    input  logic [SIG_MAX_BITS-1:0] i_signal_value,
    input  logic [IDX_W-1:0]        i_byte_index,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [BYTE_W-1:0]       o_read_byte,
    output logic                    o_range_error
);

    t_cmd              cmd;
    t_sts              sts;
    logic              out_free;
    logic              out_load;
    logic [BYTE_W-1:0] res_byte;
    logic              res_err;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_err;

    assign out_free = !r_out_valid || i_ready;

    psbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_ready    (o_ready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    psbp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_command      (i_command),
        .i_bit_position (i_bit_position),
        .i_bit_size     (i_bit_size),
        .i_signal_value (i_signal_value),
        .i_byte_index   (i_byte_index),
        .o_sts          (sts),
        .o_res_byte     (res_byte),
        .o_res_err      (res_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= res_byte;
            r_out_err  <= res_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_byte   = r_out_byte;
    assign o_range_error = r_out_err;

endmodule

// ----- dv/tb_pdu_signal_bit_packer.sv -----
`timescale 1ns / 100ps

module tb_pdu_signal_bit_packer;
    import psbp_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              range_error;
    } packer_result_t;

    class pdu_shadow;
        logic [BYTE_W-1:0] pdu_image [PDU_BYTES];
        packer_result_t    awaited_results [$];
        int                mismatches;

        function new();
            foreach (pdu_image[i]) pdu_image[i] = '0;
            mismatches = 0;
        endfunction

        function bit place_signal(int pos, int size, logic [SIG_MAX_BITS-1:0] value);
            int width;
            width = (size > SIG_MAX_BITS) ? SIG_MAX_BITS : size;
            if (pos + width > PDU_BITS) begin
                return 1'b1;
            end
            for (int k = 0; k < width; k++) begin
                pdu_image[(pos + k) / BYTE_W][(pos + k) % BYTE_W] = value[k];
            end
            return 1'b0;
        endfunction

        function void note_transaction(logic cmd, logic [POS_W-1:0] pos,
                                       logic [SIZE_W-1:0] size,
                                       logic [SIG_MAX_BITS-1:0] value,
                                       logic [IDX_W-1:0] idx);
            packer_result_t res;
            res = '0;
            if (cmd == CMD_READ) begin
                if (int'(idx) < PDU_BYTES) begin
                    res.read_byte = pdu_image[idx];
                end
            end else begin
                res.range_error = place_signal(int'(pos), int'(size), value);
            end
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [BYTE_W-1:0] read_byte, logic range_error);
            packer_result_t exp_res;
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: read_byte %0h range_error %0b",
                       read_byte, range_error);
                mismatches++;
                return;
            end
            exp_res = awaited_results.pop_front();
            if (read_byte !== exp_res.read_byte) begin
                $error("read_byte: expected %0h, got %0h", exp_res.read_byte, read_byte);
                mismatches++;
            end
            if (range_error !== exp_res.range_error) begin
                $error("range_error: expected %0b, got %0b", exp_res.range_error, range_error);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_command;
    logic [POS_W-1:0]        i_bit_position;
    logic [SIZE_W-1:0]       i_bit_size;
    logic [SIG_MAX_BITS-1:0] i_signal_value;
    logic [IDX_W-1:0]        i_byte_index;
    logic                    o_valid;
    logic                    i_ready;
    logic [BYTE_W-1:0]       o_read_byte;
    logic                    o_range_error;

    pdu_shadow shadow = new();
    int        sent_count = 0;
    int        recv_count = 0;

    pdu_signal_bit_packer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_bit_position (i_bit_position),
        .i_bit_size     (i_bit_size),
        .i_signal_value (i_signal_value),
        .i_byte_index   (i_byte_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_byte    (o_read_byte),
        .o_range_error  (o_range_error)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // bursts with no idling every fourth block of 64 transactions
    function automatic int draw_gap(int n);
        return ((n / 64) % 4 == 3) ? 0 : int'($urandom_range(0, 15));
    endfunction

    task automatic send_item(logic cmd, logic [POS_W-1:0] pos, logic [SIZE_W-1:0] size,
                             logic [SIG_MAX_BITS-1:0] value, logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_gap(sent_count);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_bit_position <= pos;
        i_bit_size     <= size;
        i_signal_value <= value;
        i_byte_index   <= idx;
        do @(posedge i_clk); while (!o_ready);
        shadow.note_transaction(cmd, pos, size, value, idx);
        sent_count++;
    endtask

    task automatic write_signal(int pos, int size, logic [SIG_MAX_BITS-1:0] value);
        send_item(CMD_WRITE, POS_W'(pos), SIZE_W'(size), value, IDX_W'($urandom));
    endtask

    task automatic read_pdu_byte(int idx);
        send_item(CMD_READ, POS_W'($urandom), SIZE_W'($urandom), {$urandom, $urandom},
                  IDX_W'(idx));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic random_write();
        int r;
        int size;
        int width;
        int pos;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            size = 0;
        end else if (r < 10) begin
            size = $urandom_range(65, 127);
        end else begin
            size = $urandom_range(1, 64);
        end
        width = (size > SIG_MAX_BITS) ? SIG_MAX_BITS : size;
        if ($urandom_range(0, 99) < 85) begin
            pos = $urandom_range(0, PDU_BITS - width);
        end else begin
            pos = $urandom_range(0, PDU_BITS - 1);
        end
        write_signal(pos, size, {$urandom, $urandom});
    endtask

    // result side
    initial begin
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap(recv_count);
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            shadow.check_result(o_read_byte, o_range_error);
            recv_count++;
        end
    end

    initial begin
        #2_000_000;
        $display("pdu_signal_bit_packer test failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_WRITE;
        i_bit_position = '0;
        i_bit_size     = '0;
        i_signal_value = '0;
        i_byte_index   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        read_pdu_byte(0);
        read_pdu_byte(PDU_BYTES - 1);
        write_signal(0, 64, '1);
        read_pdu_byte(0);
        read_pdu_byte(7);
        write_signal(3, 13, '0);
        read_pdu_byte(0);
        read_pdu_byte(1);
        write_signal(PDU_BITS - 64, 64, 64'hA5A5_5A5A_F00F_0FF0);
        read_pdu_byte(PDU_BYTES - 1);
        write_signal(PDU_BITS - 63, 64, '1);
        write_signal(PDU_BITS - 1, 1, '1);
        read_pdu_byte(PDU_BYTES - 1);
        write_signal(100, 0, '1);
        read_pdu_byte(12);
        write_signal(0, 127, 64'h0123_4567_89AB_CDEF);
        read_pdu_byte(0);
        write_signal(460, 100, '1);
        write_signal(PDU_BITS - 64, 65, 64'h8000_0000_0000_0001);
        write_signal(PDU_BITS - 1, 2, '1);
        read_pdu_byte(PDU_BYTES - 8);
        read_pdu_byte(PDU_BYTES - 1);

        // random
        for (int n = 0; n < 450; n++) begin
            if (n == 225) begin
                wait_drained();
            end
            if ($urandom_range(0, 99) < 60) begin
                random_write();
            end else begin
                read_pdu_byte($urandom_range(0, PDU_BYTES - 1));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
            $display("pdu_signal_bit_packer test passed");
        end else begin
            $display("pdu_signal_bit_packer test failed");
        end
        $finish;
    end

endmodule
